// ===== hdl/sci_pkg.sv =====
package sci_pkg;

    // Fixed field widths
    localparam int OFF_W    = 32;
    localparam int BLK_W    = 24;
    localparam int PST_W    = 32;
    localparam int STRIDE_W = 25;
    localparam int REQ_W    = 3;

    localparam logic [BLK_W-1:0]    BLOCK_MAX  = {BLK_W{1'b1}};
    localparam logic [STRIDE_W-1:0] STRIDE_MAX = STRIDE_W'(1) << BLK_W;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd0;
    localparam logic [REQ_W-1:0] REQ_BEGIN = 3'd1;
    localparam logic [REQ_W-1:0] REQ_EMIT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_END   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LOOK  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_APP_RD,
        S_APP_CMP,
        S_HALF_RD,
        S_HALF_WR,
        S_APP_WR,
        S_TRIM_RD,
        S_TRIM_CMP,
        S_LOOK_RD,
        S_LOOK_CMP,
        S_DONE
    } ctrl_state_t;

    typedef enum logic {
        RD_LAST,
        RD_IDX
    } rd_sel_t;

    typedef struct packed {
        logic    take;
        logic    clear_all;
        logic    clear_mark;
        logic    emit_mark;
        logic    bc_inc;
        logic    bc_rollback;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_app;
        logic    wr_half;
        logic    idx_clr;
        logic    idx_step1;
        logic    idx_step2;
        logic    half_end;
        logic    cnt_dec;
        logic    hit;
        logic    res_clr;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             new_mark;
        logic             app_cond;
        logic             count_zero;
        logic             count_full;
        logic             idx_lt_count;
        logic             rd_ge_bc;
        logic             rd_gt_bc;
        logic             rd_gt_query;
        logic             end_ok;
    } dp_stat_t;

endpackage

// ===== hdl/sci_datapath.sv =====
module sci_datapath #(
    parameter int TABLE_DEPTH = 64,
    parameter int MIN_STRIDE  = 4,
    parameter int STATE_BITS  = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sci_pkg::dp_cmd_t                     cmd,
    output sci_pkg::dp_stat_t                    stat,
    input  logic [sci_pkg::REQ_W-1:0]            req_type,
    input  logic [sci_pkg::OFF_W-1:0]            mark_offset,
    input  logic [sci_pkg::PST_W-1:0]            parser_state,
    input  logic [sci_pkg::BLK_W-1:0]            query_block,
    output logic                                 found,
    output logic [sci_pkg::OFF_W-1:0]            ckpt_offset,
    output logic [sci_pkg::BLK_W-1:0]            ckpt_block,
    output logic [sci_pkg::PST_W-1:0]            ckpt_state,
    output logic [sci_pkg::BLK_W-1:0]            block_total,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     entries_used,
    output logic [sci_pkg::STRIDE_W-1:0]         stride_now
);
    import sci_pkg::*;

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int ST_W = (STATE_BITS < PST_W) ? STATE_BITS : PST_W;
    localparam int EW   = OFF_W + BLK_W + ST_W;

    // Latched request
    logic [REQ_W-1:0]    req_reg;
    logic [OFF_W-1:0]    mark_in_reg;
    logic [ST_W-1:0]     pst_reg;
    logic [BLK_W-1:0]    query_reg;

    // Index state
    logic [CW-1:0]       count_reg;
    logic [STRIDE_W-1:0] spacing_reg;
    logic [BLK_W-1:0]    bc_reg;
    logic [OFF_W-1:0]    recent_mark_reg;
    logic [BLK_W-1:0]    recent_blk_reg;
    logic                mark_valid_reg;

    // Walk pointers
    logic [CW:0]         idx_reg;
    logic [CW-1:0]       w_reg;

    // Working result
    logic                hit_reg;
    logic [OFF_W-1:0]    hit_off_reg;
    logic [BLK_W-1:0]    hit_blk_reg;
    logic [ST_W-1:0]     hit_st_reg;

    // Output register
    logic                out_found_reg;
    logic [OFF_W-1:0]    out_off_reg;
    logic [BLK_W-1:0]    out_blk_reg;
    logic [ST_W-1:0]     out_st_reg;
    logic [BLK_W-1:0]    out_total_reg;
    logic [CW-1:0]       out_used_reg;
    logic [STRIDE_W-1:0] out_stride_reg;

    // Checkpoint table: {offset, block, state}
    logic [EW-1:0]       mem [TABLE_DEPTH];
    logic [EW-1:0]       rdata_reg;

    logic [CW-1:0]       last_idx;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data;
    logic                wr_en;
    logic [OFF_W-1:0]    rd_off;
    logic [BLK_W-1:0]    rd_blk;
    logic [ST_W-1:0]     rd_st;
    logic [STRIDE_W-1:0] stride_mask;

    assign last_idx = count_reg - 1'b1;
    assign rd_addr  = (cmd.rd_sel == RD_LAST) ? last_idx[AW-1:0] : idx_reg[AW-1:0];
    assign wr_addr  = cmd.wr_half ? w_reg[AW-1:0] : count_reg[AW-1:0];
    assign wr_data  = cmd.wr_half ? rdata_reg : {mark_in_reg, bc_reg, pst_reg};
    assign wr_en    = cmd.wr_half || cmd.wr_app;

    assign rd_off = rdata_reg[ST_W+BLK_W +: OFF_W];
    assign rd_blk = rdata_reg[ST_W +: BLK_W];
    assign rd_st  = rdata_reg[ST_W-1:0];

    assign stride_mask = spacing_reg - 1'b1;

    // Status toward the controller
    always_comb
    begin
        stat.req          = req_reg;
        stat.new_mark     = !mark_valid_reg || (mark_in_reg != recent_mark_reg);
        stat.app_cond     = (bc_reg == '0)
                          || ((STRIDE_W'(bc_reg) & stride_mask) == '0)
                          || (count_reg == '0);
        stat.count_zero   = (count_reg == '0);
        stat.count_full   = (count_reg >= CW'(TABLE_DEPTH));
        stat.idx_lt_count = (idx_reg < (CW+1)'(count_reg));
        stat.rd_ge_bc     = (rd_blk >= bc_reg);
        stat.rd_gt_bc     = (rd_blk > bc_reg);
        stat.rd_gt_query  = (rd_blk > query_reg);
        stat.end_ok       = mark_valid_reg && (mark_in_reg == recent_mark_reg)
                          && (bc_reg > recent_blk_reg);
    end

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Latch the accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            req_reg     <= req_type;
            mark_in_reg <= mark_offset;
            pst_reg     <= parser_state[ST_W-1:0];
            query_reg   <= query_block;
        end
    end

    // Index control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            spacing_reg     <= STRIDE_W'(MIN_STRIDE);
            bc_reg          <= '0;
            recent_mark_reg <= '0;
            recent_blk_reg  <= '0;
            mark_valid_reg  <= 1'b0;
            idx_reg         <= '0;
            w_reg           <= '0;
        end
        else
        begin
            if (cmd.clear_all)
            begin
                count_reg       <= '0;
                spacing_reg     <= STRIDE_W'(MIN_STRIDE);
                bc_reg          <= '0;
                recent_mark_reg <= '0;
                recent_blk_reg  <= '0;
                mark_valid_reg  <= 1'b0;
            end
            if (cmd.clear_mark)
            begin
                mark_valid_reg <= 1'b0;
            end
            // Remember the first sighting of a mark
            if (cmd.emit_mark)
            begin
                recent_mark_reg <= mark_in_reg;
                recent_blk_reg  <= bc_reg;
                mark_valid_reg  <= 1'b1;
            end
            if (cmd.bc_inc && (bc_reg != BLOCK_MAX))
            begin
                bc_reg <= bc_reg + 1'b1;
            end
            if (cmd.bc_rollback)
            begin
                bc_reg <= recent_blk_reg;
            end
            if (cmd.wr_app)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - 1'b1;
            end
            // Thinning: keep even entries, double the stride (capped at STRIDE_MAX)
            if (cmd.half_end)
            begin
                count_reg <= w_reg;
                if (spacing_reg >= (STRIDE_MAX >> 1))
                begin
                    spacing_reg <= STRIDE_MAX;
                end
                else
                begin
                    spacing_reg <= {spacing_reg[STRIDE_W-2:0], 1'b0};
                end
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
                w_reg   <= '0;
            end
            if (cmd.idx_step1)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.idx_step2)
            begin
                idx_reg <= idx_reg + 2'd2;
            end
            if (cmd.wr_half)
            begin
                w_reg <= w_reg + 1'b1;
            end
        end
    end

    // Lookup result capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.res_clr)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.hit)
        begin
            hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_clr)
        begin
            hit_off_reg <= '0;
            hit_blk_reg <= '0;
            hit_st_reg  <= '0;
        end
        else if (cmd.hit)
        begin
            hit_off_reg <= rd_off;
            hit_blk_reg <= rd_blk;
            hit_st_reg  <= rd_st;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_found_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_found_reg <= hit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_off_reg    <= hit_off_reg;
            out_blk_reg    <= hit_blk_reg;
            out_st_reg     <= hit_st_reg;
            out_total_reg  <= bc_reg;
            out_used_reg   <= count_reg;
            out_stride_reg <= spacing_reg;
        end
    end

    assign found        = out_found_reg;
    assign ckpt_offset  = out_off_reg;
    assign ckpt_block   = out_blk_reg;
    assign ckpt_state   = PST_W'(out_st_reg);
    assign block_total  = out_total_reg;
    assign entries_used = out_used_reg;
    assign stride_now   = out_stride_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_stride_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(spacing_reg))
        else $error("stride lost its power-of-two form");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_app |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not advance the entry count");

endmodule

// ===== hdl/sci_ctrl.sv =====
module sci_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  sci_pkg::dp_stat_t stat,
    output sci_pkg::dp_cmd_t  cmd
);
    import sci_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_LAST;
        cmd.take   = in_valid && in_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.res_clr = 1'b1;
                state_next  = S_DONE;
                case (stat.req)
                    REQ_CLEAR: cmd.clear_all  = 1'b1;
                    REQ_BEGIN: cmd.clear_mark = 1'b1;
                    REQ_EMIT:
                    begin
                        if (stat.new_mark)
                        begin
                            cmd.emit_mark = 1'b1;
                        end
                        if (stat.new_mark && stat.app_cond)
                        begin
                            state_next = stat.count_zero ? S_APP_WR : S_APP_RD;
                        end
                        else
                        begin
                            cmd.bc_inc = 1'b1;
                        end
                    end
                    REQ_END:
                    begin
                        if (stat.end_ok)
                        begin
                            cmd.bc_rollback = 1'b1;
                            state_next      = S_TRIM_RD;
                        end
                    end
                    REQ_LOOK:
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_LOOK_RD;
                    end
                    default: ;
                endcase
            end
            // Fetch the newest entry
            S_APP_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LAST;
                state_next = S_APP_CMP;
            end
            S_APP_CMP:
            begin
                if (stat.rd_ge_bc)
                begin
                    cmd.bc_inc = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.count_full)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_HALF_RD;
                end
                else
                begin
                    state_next = S_APP_WR;
                end
            end
            // Thin the table: copy every other entry down
            S_HALF_RD:
            begin
                if (stat.idx_lt_count)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = S_HALF_WR;
                end
                else
                begin
                    cmd.half_end = 1'b1;
                    state_next   = S_APP_WR;
                end
            end
            S_HALF_WR:
            begin
                cmd.wr_half   = 1'b1;
                cmd.idx_step2 = 1'b1;
                state_next    = S_HALF_RD;
            end
            S_APP_WR:
            begin
                cmd.wr_app = 1'b1;
                cmd.bc_inc = 1'b1;
                state_next = S_DONE;
            end
            // Drop entries past the rolled-back count
            S_TRIM_RD:
            begin
                if (stat.count_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LAST;
                    state_next = S_TRIM_CMP;
                end
            end
            S_TRIM_CMP:
            begin
                if (stat.rd_gt_bc)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_TRIM_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            // Scan forward for the last entry at or before the query
            S_LOOK_RD:
            begin
                if (stat.idx_lt_count)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = S_LOOK_CMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LOOK_CMP:
            begin
                if (stat.rd_gt_query)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.hit       = 1'b1;
                    cmd.idx_step1 = 1'b1;
                    state_next    = S_LOOK_RD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_EXEC)
        else $error("accepted beat not dispatched");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (state_reg == S_DONE) && (!out_valid_reg || out_ready))
        else $error("result loaded over a pending beat");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_app && cmd.wr_half))
        else $error("two table writes in one cycle");

endmodule

// ===== hdl/sparse_checkpoint_index.sv =====
// Sparse checkpoint index: a bounded table of resume points for a parsed stream.
// Input channel (in_valid/in_ready) carries one request per beat: clear all,
// begin pass, block emitted, end pass or lookup. Output channel
// (out_valid/out_ready) returns exactly one result beat per request, with the
// lookup hit (zero for other requests) and the block count, entry count and
// stride after that request.
// Each request passes from idle through the execute state to the done state,
// where the result beat is loaded once the output register is free. An emit
// that may append first reads and compares the newest entry, unless the table
// is empty, and a full table is thinned by reading and writing back every
// other entry. An end pass with rollback reads and drops trailing entries one
// by one; a lookup reads held entries in order until one lies past the query
// or all are read. Each walked entry is read from the table in one state and
// compared or copied in the next. One request is worked on at a time;
// the next beat is accepted while a finished result waits in the output
// register, so a stalled receiver lets one more request run, which then waits
// in its final state until the output register frees.
// Reset clears the entry count, block count and mark, and sets the stride to
// its minimum; table contents need no clearing, as only held entries are read.
module sparse_checkpoint_index #(
    parameter int TABLE_DEPTH = 64,
    parameter int MIN_STRIDE  = 4,
    parameter int STATE_BITS  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sci_pkg::REQ_W-1:0]        req_type,
    input  logic [sci_pkg::OFF_W-1:0]        mark_offset,
    input  logic [sci_pkg::PST_W-1:0]        parser_state,
    input  logic [sci_pkg::BLK_W-1:0]        query_block,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             found,
    output logic [sci_pkg::OFF_W-1:0]        ckpt_offset,
    output logic [sci_pkg::BLK_W-1:0]        ckpt_block,
    output logic [sci_pkg::PST_W-1:0]        ckpt_state,
    output logic [sci_pkg::BLK_W-1:0]        block_total,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] entries_used,
    output logic [sci_pkg::STRIDE_W-1:0]     stride_now
);
    import sci_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sci_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sci_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MIN_STRIDE  (MIN_STRIDE),
        .STATE_BITS  (STATE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .mark_offset  (mark_offset),
        .parser_state (parser_state),
        .query_block  (query_block),
        .found        (found),
        .ckpt_offset  (ckpt_offset),
        .ckpt_block   (ckpt_block),
        .ckpt_state   (ckpt_state),
        .block_total  (block_total),
        .entries_used (entries_used),
        .stride_now   (stride_now)
    );

endmodule

// ===== tb/sparse_checkpoint_index_test.sv =====
`timescale 1ns / 1ps

module sparse_checkpoint_index_test;

    import sci_pkg::*;

    localparam int DEPTH        = 64;
    localparam int MIN_STRIDE   = 4;
    localparam int ENTRY_W      = $clog2(DEPTH + 1);
    localparam int TOTAL_ITEMS  = 1100;
    localparam int TAIL_CYCLES  = 200;
    localparam int CALM_FIRST   = 350;
    localparam int CALM_LAST    = 550;
    localparam int DRAIN_POINT  = 700;

    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = REQ_LOOK + 1'b1;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = '1;

    typedef struct packed {
        logic                hit;
        logic [OFF_W-1:0]    off;
        logic [BLK_W-1:0]    blk;
        logic [PST_W-1:0]    st;
        logic [BLK_W-1:0]    total;
        logic [ENTRY_W-1:0]  used;
        logic [STRIDE_W-1:0] stride;
    } index_status_t;

    // Track the checkpoint table and queue the status each request should return
    class index_tracker;
        logic [OFF_W-1:0]    ckpt_offs[DEPTH];
        logic [BLK_W-1:0]    ckpt_blks[DEPTH];
        logic [PST_W-1:0]    ckpt_sts[DEPTH];
        int unsigned         used;
        logic [STRIDE_W-1:0] stride;
        logic [BLK_W-1:0]    count;
        logic [OFF_W-1:0]    mark_off;
        logic [BLK_W-1:0]    mark_blk;
        logic                mark_seen;
        index_status_t       expected_status[$];
        int unsigned         errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            used      = 0;
            stride    = STRIDE_W'(MIN_STRIDE);
            count     = '0;
            mark_off  = '0;
            mark_blk  = '0;
            mark_seen = 1'b0;
        endfunction

        // Keep every other entry and double the spacing, capped at STRIDE_MAX
        function void thin();
            int unsigned w;
            w = 0;
            for (int unsigned i = 0; i < used; i += 2) begin
                ckpt_offs[w] = ckpt_offs[i];
                ckpt_blks[w] = ckpt_blks[i];
                ckpt_sts[w]  = ckpt_sts[i];
                w++;
            end
            used   = w;
            stride = (stride >= STRIDE_MAX / 2) ? STRIDE_MAX : STRIDE_W'(stride * 2);
        endfunction

        function void add_checkpoint(logic [OFF_W-1:0] off, logic [BLK_W-1:0] blk,
                                     logic [PST_W-1:0] st);
            if (used > 0 && ckpt_blks[used-1] >= blk)
                return;
            if (used >= DEPTH)
                thin();
            if (used >= DEPTH)
                return;
            ckpt_offs[used] = off;
            ckpt_blks[used] = blk;
            ckpt_sts[used]  = st;
            used++;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [OFF_W-1:0] off,
                                   logic [PST_W-1:0] pst, logic [BLK_W-1:0] qry);
            index_status_t r;
            r = '0;
            case (req)
                REQ_CLEAR: clear();
                REQ_BEGIN: mark_seen = 1'b0;
                REQ_EMIT:
                begin
                    // A new mark may record a checkpoint at the current count
                    if (!mark_seen || off != mark_off) begin
                        if (count == 0 || (count % stride) == 0 || used == 0)
                            add_checkpoint(off, count, pst);
                        mark_off  = off;
                        mark_blk  = count;
                        mark_seen = 1'b1;
                    end
                    if (count != BLOCK_MAX)
                        count++;
                end
                REQ_END:
                begin
                    // Roll back to the mark and drop entries past it
                    if (mark_seen && off == mark_off && count > mark_blk) begin
                        count = mark_blk;
                        while (used > 0 && ckpt_blks[used-1] > count)
                            used--;
                    end
                end
                REQ_LOOK:
                begin
                    for (int unsigned i = 0; i < used; i++) begin
                        if (ckpt_blks[i] > qry)
                            break;
                        r.hit = 1'b1;
                        r.off = ckpt_offs[i];
                        r.blk = ckpt_blks[i];
                        r.st  = ckpt_sts[i];
                    end
                end
                default: ;
            endcase
            r.total  = count;
            r.used   = ENTRY_W'(used);
            r.stride = stride;
            expected_status.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_status(index_status_t got);
            index_status_t want;
            if (expected_status.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
                return;
            end
            want = expected_status.pop_front();
            compare_field("found",        want.hit,    got.hit);
            compare_field("ckpt_offset",  want.off,    got.off);
            compare_field("ckpt_block",   want.blk,    got.blk);
            compare_field("ckpt_state",   want.st,     got.st);
            compare_field("block_total",  want.total,  got.total);
            compare_field("entries_used", want.used,   got.used);
            compare_field("stride_now",   want.stride, got.stride);
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [REQ_W-1:0]    req_type = '0;
    logic [OFF_W-1:0]    mark_offset = '0;
    logic [PST_W-1:0]    parser_state = '0;
    logic [BLK_W-1:0]    query_block = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                found;
    logic [OFF_W-1:0]    ckpt_offset;
    logic [BLK_W-1:0]    ckpt_block;
    logic [PST_W-1:0]    ckpt_state;
    logic [BLK_W-1:0]    block_total;
    logic [ENTRY_W-1:0]  entries_used;
    logic [STRIDE_W-1:0] stride_now;

    index_tracker tracker = new();
    logic         calm = 1'b0;
    int           items_sent = 0;

    sparse_checkpoint_index #(
        .TABLE_DEPTH(DEPTH),
        .MIN_STRIDE (MIN_STRIDE),
        .STATE_BITS (PST_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .mark_offset (mark_offset),
        .parser_state(parser_state),
        .query_block (query_block),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .ckpt_offset (ckpt_offset),
        .ckpt_block  (ckpt_block),
        .ckpt_state  (ckpt_state),
        .block_total (block_total),
        .entries_used(entries_used),
        .stride_now  (stride_now)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Check each result beat and stall the output at random
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            tracker.check_status('{found, ckpt_offset, ckpt_block, ckpt_state,
                                   block_total, entries_used, stride_now});
        out_ready <= calm || ($urandom_range(99) >= 21);
    end

    // Drive one request beat, at times with a random idle gap ahead of it outside calm phases
    task automatic send(input logic [REQ_W-1:0] req, input logic [OFF_W-1:0] off,
                        input logic [PST_W-1:0] pst, input logic [BLK_W-1:0] qry);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 21)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        mark_offset  <= off;
        parser_state <= pst;
        query_block  <= qry;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_request(req, off, pst, qry);
        items_sent++;
    endtask

    // Hold off the sender until every result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_lookup();
        logic [BLK_W-1:0] q;
        int               pick;
        pick = $urandom_range(99);
        if (pick < 10)
            q = BLK_W'($urandom);
        else if (pick < 45 && tracker.used > 0)
            q = tracker.ckpt_blks[$urandom_range(tracker.used - 1)] - BLK_W'(pick & 1);
        else
            q = BLK_W'($urandom_range(tracker.count + 4));
        send(REQ_LOOK, $urandom, $urandom, q);
    endtask

    // Single stray beat: unused codes, unmatched end pass, lone emit, and so on
    task automatic send_noise();
        case ($urandom_range(4))
            0: send(REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), $urandom,
                    $urandom, BLK_W'($urandom));
            1: send(REQ_END, $urandom, $urandom, BLK_W'($urandom));
            2: send(REQ_EMIT, $urandom, $urandom, BLK_W'($urandom));
            3: send(REQ_BEGIN, $urandom, $urandom, BLK_W'($urandom));
            default: send(REQ_LOOK, $urandom, $urandom, BLK_W'($urandom));
        endcase
    endtask

    // One parse pass: begin, marks spanning one to three blocks each with occasional lookups, end pass, then lookups
    task automatic run_pass();
        int               marks;
        int               reps;
        logic [OFF_W-1:0] m;
        marks = $urandom_range(3, 20);
        m = $urandom;
        send(REQ_BEGIN, $urandom, $urandom, BLK_W'($urandom));
        for (int k = 0; k < marks; k++) begin
            m = $urandom;
            reps = $urandom_range(1, 3);
            for (int r = 0; r < reps; r++)
                send(REQ_EMIT, m, $urandom, BLK_W'($urandom));
            if ($urandom_range(99) < 20)
                send_lookup();
        end
        send(REQ_END, ($urandom_range(99) < 80) ? m : OFF_W'($urandom), $urandom,
             BLK_W'($urandom));
        repeat ($urandom_range(1, 3)) send_lookup();
    endtask

    initial
    begin
        bit drained_mid;
        int pick;
        drained_mid = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, repeated marks, rollback, lookup edges
        send(REQ_LOOK,  '0, '0, '0);
        send(REQ_END,   '0, '0, '0);
        send(REQ_BEGIN, '0, '0, '0);
        send(REQ_EMIT,  '0, '0, '0);
        send(REQ_EMIT,  '0, '1, '1);
        send(REQ_EMIT,  32'd1, 32'd1, '0);
        send(REQ_EMIT,  32'd2, 32'd2, '0);
        send(REQ_EMIT,  '1, '1, '1);
        send(REQ_EMIT,  '1, 32'h5a5a_5a5a, '0);
        send(REQ_EMIT,  '1, 32'ha5a5_a5a5, '0);
        send(REQ_END,   32'h1234_5678, '0, '0);
        send(REQ_END,   '1, '0, '0);
        send(REQ_END,   '1, '0, '0);
        send(REQ_LOOK,  '0, '0, 24'd0);
        send(REQ_LOOK,  '0, '0, 24'd3);
        send(REQ_LOOK,  '0, '0, 24'd4);
        send(REQ_LOOK,  '1, '1, '1);
        send(REQ_BEGIN, '0, '0, '0);
        send(REQ_EMIT,  '1, 32'h0f0f_0f0f, '0);
        for (int u = REQ_UNUSED_LO; u <= REQ_UNUSED_HI; u++)
            send(REQ_W'(u), $urandom, $urandom, BLK_W'($urandom));
        send(REQ_CLEAR, '0, '0, '0);
        send(REQ_LOOK,  '0, '0, '1);
        drain();

        // Random: mostly well-formed passes, some noise and rare clears
        while (items_sent < TOTAL_ITEMS) begin
            calm = (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
            if (!drained_mid && items_sent >= DRAIN_POINT) begin
                drain();
                drained_mid = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 2)
                send(REQ_CLEAR, $urandom, $urandom, BLK_W'($urandom));
            else if (pick < 12)
                send_noise();
            else
                run_pass();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Bound the run in case a handshake never completes
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
